FILE: hw/rtl/i2c_eeprom_byte_master_assert.svh
// assertion macros for the rtl top level
`ifndef I2C_EEPROM_BYTE_MASTER_ASSERT_SVH
`define I2C_EEPROM_BYTE_MASTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define I2CEE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("i2cee assertion failed");

// next-cycle implication, checked out of reset
`define I2CEE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("i2cee assertion failed");

`endif

FILE: hw/rtl/i2cee_pkg.sv
`default_nettype none

package i2cee_pkg;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START    = 4'd1,
        PH_DEV      = 4'd2,
        PH_AHI      = 4'd3,
        PH_ALO      = 4'd4,
        PH_DATA     = 4'd5,
        PH_RSTART   = 4'd6,
        PH_DEVR     = 4'd7,
        PH_RX       = 4'd8,
        PH_STOP     = 4'd9,
        PH_STOP_ERR = 4'd10,
        PH_WAIT     = 4'd11
    } phase_t;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] CFG_DEV_ADDR   = 3'd0;
    localparam logic [2:0] CFG_WIDE_MODE  = 3'd1;
    localparam logic [2:0] CFG_QUARTER    = 3'd2;
    localparam logic [2:0] CFG_ACK_TMO    = 3'd3;
    localparam logic [2:0] CFG_WRITE_WAIT = 3'd4;

    localparam logic [6:0]  DEV_ADDR_RST   = 7'd80;
    localparam logic [15:0] QUARTER_RST    = 16'd500;
    localparam logic [7:0]  ACK_TMO_RST    = 8'd250;
    localparam logic [31:0] WRITE_WAIT_RST = 32'd250000;

    localparam logic [3:0] BIT_ACK_SETUP = 4'd8;
    localparam logic [3:0] BIT_ACK_POLL  = 4'd9;
    localparam logic [2:0] QI_FULL_BIT   = 3'd4;

    typedef struct packed {
        logic [6:0]  device_address;
        logic        wide_address_mode;
        logic [15:0] quarter_period_ticks;
        logic [7:0]  ack_timeout_ticks;
        logic [31:0] write_wait_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  bit_count;
        logic [7:0]  shift_byte;
        logic [15:0] quarter_count;
        logic [2:0]  quarter_index;
        logic [31:0] wait_count;
        logic [7:0]  ack_wait_count;
        logic [15:0] held_address;
        logic [7:0]  held_write_data;
        logic        held_is_write;
        logic [7:0]  last_read_byte;
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] mem_address;
        logic [7:0]  write_data;
        logic        sda_in;
    } req_t;

    typedef struct packed {
        logic       ack_error;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive_low;
        logic       scl_level;
    } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2cee_cfg.sv
`default_nettype none

module i2cee_cfg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [2:0]        cfg_wr_index,
    input  wire logic [31:0]       cfg_wr_data,
    output i2cee_pkg::cfg_t        cfg
);
    import i2cee_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address       <= DEV_ADDR_RST;
            cfg_reg.wide_address_mode    <= 1'b0;
            cfg_reg.quarter_period_ticks <= QUARTER_RST;
            cfg_reg.ack_timeout_ticks    <= ACK_TMO_RST;
            cfg_reg.write_wait_ticks     <= WRITE_WAIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_DEV_ADDR:   cfg_reg.device_address       <= cfg_wr_data[6:0];
                CFG_WIDE_MODE:  cfg_reg.wide_address_mode    <= cfg_wr_data[0];
                CFG_QUARTER:    cfg_reg.quarter_period_ticks <= cfg_wr_data[15:0];
                CFG_ACK_TMO:    cfg_reg.ack_timeout_ticks    <= cfg_wr_data[7:0];
                CFG_WRITE_WAIT: cfg_reg.write_wait_ticks     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cee_step.sv
`default_nettype none

// one bus tick: next sequencer state and the pin/status result for it
module i2cee_step (
    input  i2cee_pkg::cfg_t   cfg,
    input  i2cee_pkg::state_t cur,
    input  i2cee_pkg::req_t   req,
    output i2cee_pkg::state_t nxt,
    output i2cee_pkg::res_t   res
);
    import i2cee_pkg::*;

    logic [15:0] q;
    logic [15:0] q_m1;
    logic        qc_wrap;
    logic [15:0] qc_tick;
    logic [2:0]  qi_tick;
    logic [32:0] wait_inc;
    logic [6:0]  dev_sum;
    logic [7:0]  dev_byte;
    logic [7:0]  rx_shift;
    logic [3:0]  bc_inc;
    logic        done;
    logic        err;
    logic        qi_mid;

    assign q        = (cfg.quarter_period_ticks == 16'd0) ? 16'd1 : cfg.quarter_period_ticks;
    assign q_m1     = q - 16'd1;
    assign qc_wrap  = (cur.quarter_count == q_m1);
    assign qc_tick  = qc_wrap ? 16'd0 : cur.quarter_count + 16'd1;
    assign qi_tick  = qc_wrap ? cur.quarter_index + 3'd1 : cur.quarter_index;
    assign wait_inc = {1'b0, cur.wait_count} + 33'd1;
    assign bc_inc   = cur.bit_count + 4'd1;

    // narrow mode folds address bits [14:8] of the high byte into the device address
    assign dev_sum  = cfg.wide_address_mode ? cfg.device_address
                    : cfg.device_address + cur.held_address[14:8];
    assign dev_byte = {dev_sum, 1'b0};

    always_comb begin
        nxt      = cur;
        done     = 1'b0;
        err      = 1'b0;
        rx_shift = cur.shift_byte;

        case (cur.phase)
            PH_IDLE: begin
                if (req.opcode == OP_WRITE || req.opcode == OP_READ) begin
                    nxt.held_address    = req.mem_address;
                    nxt.held_write_data = req.write_data;
                    nxt.held_is_write   = (req.opcode == OP_WRITE);
                    nxt.phase           = PH_START;
                    nxt.shift_byte      = 8'd0;
                    nxt.bit_count       = 4'd0;
                    nxt.quarter_count   = 16'd0;
                    nxt.quarter_index   = 3'd0;
                    nxt.wait_count      = 32'd0;
                    nxt.ack_wait_count  = 8'd0;
                end
            end
            PH_START, PH_RSTART: begin
                nxt.quarter_count = qc_tick;
                nxt.quarter_index = qi_tick;
                if (qi_tick == QI_FULL_BIT) begin
                    nxt.phase         = (cur.phase == PH_START) ? PH_DEV : PH_DEVR;
                    nxt.shift_byte    = (cur.phase == PH_START) ? dev_byte
                                                                : (dev_byte | 8'h01);
                    nxt.bit_count     = 4'd0;
                    nxt.quarter_count = 16'd0;
                    nxt.quarter_index = 3'd0;
                    nxt.wait_count    = 32'd0;
                    nxt.ack_wait_count = 8'd0;
                end
            end
            PH_DEV, PH_AHI, PH_ALO, PH_DATA, PH_DEVR: begin
                if (cur.bit_count < BIT_ACK_SETUP) begin
                    nxt.quarter_count = qc_tick;
                    nxt.quarter_index = qi_tick;
                    if (qi_tick == QI_FULL_BIT) begin
                        nxt.quarter_count = 16'd0;
                        nxt.quarter_index = 3'd0;
                        nxt.shift_byte    = {cur.shift_byte[6:0], 1'b0};
                        nxt.bit_count     = bc_inc;
                    end
                end else if (cur.bit_count == BIT_ACK_SETUP) begin
                    nxt.quarter_count = qc_tick;
                    nxt.quarter_index = qi_tick;
                    if (qi_tick != 3'd0) begin
                        nxt.quarter_count = 16'd0;
                        nxt.quarter_index = 3'd0;
                        nxt.bit_count     = BIT_ACK_POLL;
                    end
                end else if (cur.bit_count == BIT_ACK_POLL) begin
                    if (!req.sda_in) begin
                        nxt.quarter_count = 16'd0;
                        nxt.quarter_index = 3'd0;
                        nxt.bit_count     = bc_inc;
                    end else if (cur.ack_wait_count >= cfg.ack_timeout_ticks) begin
                        nxt.phase          = PH_STOP_ERR;
                        nxt.shift_byte     = 8'd0;
                        nxt.bit_count      = 4'd0;
                        nxt.quarter_count  = 16'd0;
                        nxt.quarter_index  = 3'd0;
                        nxt.wait_count     = 32'd0;
                        nxt.ack_wait_count = 8'd0;
                    end else begin
                        nxt.ack_wait_count = cur.ack_wait_count + 8'd1;
                    end
                end else begin
                    nxt.quarter_count = qc_tick;
                    nxt.quarter_index = qi_tick;
                    if (qi_tick != 3'd0) begin
                        // acknowledge done, move on to the next phase of the transaction
                        nxt.bit_count      = 4'd0;
                        nxt.quarter_count  = 16'd0;
                        nxt.quarter_index  = 3'd0;
                        nxt.wait_count     = 32'd0;
                        nxt.ack_wait_count = 8'd0;
                        case (cur.phase)
                            PH_DEV: begin
                                nxt.phase      = cfg.wide_address_mode ? PH_AHI : PH_ALO;
                                nxt.shift_byte = cfg.wide_address_mode
                                               ? cur.held_address[15:8]
                                               : cur.held_address[7:0];
                            end
                            PH_AHI: begin
                                nxt.phase      = PH_ALO;
                                nxt.shift_byte = cur.held_address[7:0];
                            end
                            PH_ALO: begin
                                nxt.phase      = cur.held_is_write ? PH_DATA : PH_RSTART;
                                nxt.shift_byte = cur.held_is_write ? cur.held_write_data
                                                                   : 8'd0;
                            end
                            PH_DATA: begin
                                nxt.phase      = PH_STOP;
                                nxt.shift_byte = 8'd0;
                            end
                            default: begin
                                nxt.phase      = PH_RX;
                                nxt.shift_byte = 8'd0;
                            end
                        endcase
                    end
                end
            end
            PH_RX: begin
                // sample on the last tick of the second quarter
                if (cur.bit_count < BIT_ACK_SETUP && cur.quarter_index == 3'd1 && qc_wrap)
                    rx_shift = {cur.shift_byte[6:0], req.sda_in};
                nxt.shift_byte    = rx_shift;
                nxt.quarter_count = qc_tick;
                nxt.quarter_index = qi_tick;
                if (qi_tick == QI_FULL_BIT) begin
                    nxt.quarter_count = 16'd0;
                    nxt.quarter_index = 3'd0;
                    nxt.bit_count     = bc_inc;
                    if (bc_inc == BIT_ACK_SETUP)
                        nxt.last_read_byte = rx_shift;
                    if (bc_inc > BIT_ACK_SETUP) begin
                        nxt.phase          = PH_STOP;
                        nxt.shift_byte     = 8'd0;
                        nxt.bit_count      = 4'd0;
                        nxt.wait_count     = 32'd0;
                        nxt.ack_wait_count = 8'd0;
                    end
                end
            end
            PH_STOP, PH_STOP_ERR: begin
                nxt.quarter_count = qc_tick;
                nxt.quarter_index = qi_tick;
                if (qi_tick == QI_FULL_BIT) begin
                    nxt.shift_byte     = 8'd0;
                    nxt.bit_count      = 4'd0;
                    nxt.quarter_count  = 16'd0;
                    nxt.quarter_index  = 3'd0;
                    nxt.wait_count     = 32'd0;
                    nxt.ack_wait_count = 8'd0;
                    if (cur.phase == PH_STOP_ERR) begin
                        err       = 1'b1;
                        done      = 1'b1;
                        nxt.phase = PH_IDLE;
                    end else if (cur.held_is_write && cfg.write_wait_ticks != 32'd0) begin
                        nxt.phase = PH_WAIT;
                    end else begin
                        done      = 1'b1;
                        nxt.phase = PH_IDLE;
                    end
                end
            end
            PH_WAIT: begin
                nxt.wait_count = wait_inc[31:0];
                if (wait_inc >= {1'b0, cfg.write_wait_ticks}) begin
                    done               = 1'b1;
                    nxt.phase          = PH_IDLE;
                    nxt.shift_byte     = 8'd0;
                    nxt.bit_count      = 4'd0;
                    nxt.quarter_count  = 16'd0;
                    nxt.quarter_index  = 3'd0;
                    nxt.wait_count     = 32'd0;
                    nxt.ack_wait_count = 8'd0;
                end
            end
            default: begin
                nxt.phase          = PH_IDLE;
                nxt.shift_byte     = 8'd0;
                nxt.bit_count      = 4'd0;
                nxt.quarter_count  = 16'd0;
                nxt.quarter_index  = 3'd0;
                nxt.wait_count     = 32'd0;
                nxt.ack_wait_count = 8'd0;
            end
        endcase
    end

    // pin levels follow the state after this tick
    assign qi_mid = (nxt.quarter_index == 3'd1 || nxt.quarter_index == 3'd2);

    always_comb begin
        res.scl_level     = 1'b1;
        res.sda_drive_low = 1'b0;
        case (nxt.phase)
            PH_START, PH_RSTART: begin
                res.scl_level     = qi_mid;
                res.sda_drive_low = (nxt.quarter_index >= 3'd2);
            end
            PH_DEV, PH_AHI, PH_ALO, PH_DATA, PH_DEVR: begin
                if (nxt.bit_count < BIT_ACK_SETUP) begin
                    res.scl_level     = qi_mid;
                    res.sda_drive_low = !nxt.shift_byte[7];
                end else begin
                    res.scl_level     = (nxt.bit_count == BIT_ACK_POLL);
                end
            end
            PH_RX: res.scl_level = qi_mid;
            PH_STOP, PH_STOP_ERR: begin
                res.scl_level     = (nxt.quarter_index != 3'd0);
                res.sda_drive_low = (nxt.quarter_index <= 3'd1);
            end
            default: ;
        endcase
        res.busy_res  = (nxt.phase != PH_IDLE);
        res.done_res  = done;
        res.read_data = nxt.last_read_byte;
        res.ack_error = err;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_eeprom_byte_master.sv
// the result is registered at the edge that accepts its tick
// throughput: one tick per cycle; the sequencer state and the output register both
// update on every accepted transaction, input stalls only while a result waits
// bus timing counts accepted ticks, not clock cycles
// reset (aresetn, synchronous, active low): sequencer idle, counters and read byte
// cleared, output empty, configuration back to its default values
`default_nettype none

module i2c_eeprom_byte_master (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_index,
    input  wire logic [31:0] cfg_wr_data,
    // ticks in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] opcode, [17:2] mem_address, [25:18] write_data, [26] sda_in, rest zero
    input  wire logic [31:0] s_tdata,
    // results out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] scl_level, [1] sda_drive_low, [2] busy_res, [3] done_res,
    // [11:4] read_data, [12] ack_error, rest zero
    output logic [15:0]      m_tdata
);
    import i2cee_pkg::*;

    cfg_t   cfg;
    state_t state_reg;
    state_t state_next;
    req_t   req;
    res_t   res;
    logic   accept;
    logic   m_tvalid_reg;
    res_t   m_res_reg;

    i2cee_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    assign req.opcode      = s_tdata[1:0];
    assign req.mem_address = s_tdata[17:2];
    assign req.write_data  = s_tdata[25:18];
    assign req.sda_in      = s_tdata[26];

    i2cee_step u_step (
        .cfg (cfg),
        .cur (state_reg),
        .req (req),
        .nxt (state_next),
        .res (res)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase          <= PH_IDLE;
            state_reg.bit_count      <= 4'd0;
            state_reg.shift_byte     <= 8'd0;
            state_reg.quarter_count  <= 16'd0;
            state_reg.quarter_index  <= 3'd0;
            state_reg.wait_count     <= 32'd0;
            state_reg.ack_wait_count <= 8'd0;
            state_reg.held_address   <= 16'd0;
            state_reg.held_write_data <= 8'd0;
            state_reg.held_is_write  <= 1'b0;
            state_reg.last_read_byte <= 8'd0;
            m_tvalid_reg             <= 1'b0;
            m_res_reg                <= '0;
        end else begin
            if (accept) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
                m_res_reg    <= res;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, m_res_reg};

`include "i2c_eeprom_byte_master_assert.svh"

    `I2CEE_ASSERT_IMP(a_done_not_busy, m_tvalid_reg && m_res_reg.done_res, !m_res_reg.busy_res)
    `I2CEE_ASSERT_IMP(a_err_with_done, m_tvalid_reg && m_res_reg.ack_error, m_res_reg.done_res)
    `I2CEE_ASSERT_IMP(a_qi_range, 1'b1, state_reg.quarter_index <= 3'd3)
    `I2CEE_ASSERT_NXT(a_idle_cleared, accept && state_next.phase == PH_IDLE,
                      state_reg.quarter_index == 3'd0 && state_reg.bit_count == 4'd0)

endmodule

`default_nettype wire

FILE: dv/tb_i2c_eeprom_byte_master.sv
`default_nettype none

module tb_i2c_eeprom_byte_master;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cee_pkg::*;

    localparam logic [3:0] BYTE_BITS    = 4'd8;
    localparam logic [3:0] BIT_ACK_HOLD = 4'd10;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_wr_index;
    logic [31:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    // [1:0] opcode, [17:2] mem_address, [25:18] write_data, [26] sda_in, rest zero
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [0] scl_level, [1] sda_drive_low, [2] busy_res, [3] done_res,
    // [11:4] read_data, [12] ack_error, rest zero
    logic [15:0] m_tdata;

    i2c_eeprom_byte_master i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    // configuration as the sequencer sees it
    logic [6:0]  c_dev;
    logic        c_wide;
    logic [15:0] c_quarter;
    logic [7:0]  c_ack_tmo;
    logic [31:0] c_wait;

    // sequencer state mirror
    phase_t      ph;
    logic [3:0]  bc;
    logic [7:0]  sh;
    logic [31:0] tc;
    logic [7:0]  awc;
    logic [15:0] h_addr;
    logic [7:0]  h_wdata;
    logic        h_wr;
    logic [7:0]  rd_byte;

    res_t expected_pins_q[$];
    int   fault_count = 0;
    int   ticks_sent = 0;
    bit   tx_jitter = 1'b0;
    bit   rx_jitter = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #30_000_000;
        $display("i2c_eeprom_byte_master: mismatch");
        $finish;
    end

    function automatic void reset_sequencer();
        c_dev = DEV_ADDR_RST;
        c_wide = 1'b0;
        c_quarter = QUARTER_RST;
        c_ack_tmo = ACK_TMO_RST;
        c_wait = WRITE_WAIT_RST;
        ph = PH_IDLE;
        bc = '0;
        sh = '0;
        tc = '0;
        awc = '0;
        h_addr = '0;
        h_wdata = '0;
        h_wr = 1'b0;
        rd_byte = '0;
    endfunction

    function automatic void enter_phase(input phase_t p, input logic [7:0] load);
        ph = p;
        sh = load;
        bc = '0;
        tc = '0;
        awc = '0;
    endfunction

    // narrow mode folds upper address bits [14:8] into the device byte, wrapping at 8 bits
    function automatic logic [7:0] dev_select_byte();
        logic [7:0] b;
        b = {c_dev, 1'b0};
        if (!c_wide)
            b = b + {h_addr[14:8], 1'b0};
        return b & 8'hFE;
    endfunction

    function automatic void ack_accepted();
        case (ph)
            PH_DEV: begin
                if (c_wide) enter_phase(PH_AHI, h_addr[15:8]);
                else enter_phase(PH_ALO, h_addr[7:0]);
            end
            PH_AHI: enter_phase(PH_ALO, h_addr[7:0]);
            PH_ALO: begin
                if (h_wr) enter_phase(PH_DATA, h_wdata);
                else enter_phase(PH_RSTART, 8'h00);
            end
            PH_DATA: enter_phase(PH_STOP, 8'h00);
            default: enter_phase(PH_RX, 8'h00);
        endcase
    endfunction

    // one tick of a sent byte plus ack poll; returns 1 when the ack timed out
    function automatic bit send_bit_tick(input logic [31:0] qtr, input logic sda);
        if (bc < BIT_ACK_SETUP) begin
            tc++;
            if (tc >= 4 * qtr) begin
                tc = '0;
                sh = sh << 1;
                bc++;
            end
        end else if (bc == BIT_ACK_SETUP) begin
            tc++;
            if (tc >= qtr) begin
                tc = '0;
                bc = BIT_ACK_POLL;
            end
        end else if (bc == BIT_ACK_POLL) begin
            if (!sda) begin
                tc = '0;
                bc = BIT_ACK_HOLD;
            end else if (awc >= c_ack_tmo) begin
                return 1'b1;
            end else begin
                awc++;
            end
        end else begin
            tc++;
            if (tc >= qtr) ack_accepted();
        end
        return 1'b0;
    endfunction

    function automatic res_t step_bus_sequencer(input logic [1:0] op, input logic [15:0] addr,
                                                input logic [7:0] wdata, input logic sda);
        logic [31:0] qtr;
        logic [31:0] qi;
        res_t        r;
        r = '0;
        qtr = (c_quarter == '0) ? 32'd1 : {16'd0, c_quarter};
        case (ph)
            PH_IDLE: begin
                if (op == OP_WRITE || op == OP_READ) begin
                    h_addr = addr;
                    h_wdata = wdata;
                    h_wr = (op == OP_WRITE);
                    enter_phase(PH_START, 8'h00);
                end
            end
            PH_START, PH_RSTART: begin
                tc++;
                if (tc >= 4 * qtr) begin
                    if (ph == PH_START) enter_phase(PH_DEV, dev_select_byte());
                    else enter_phase(PH_DEVR, dev_select_byte() | 8'h01);
                end
            end
            PH_DEV, PH_AHI, PH_ALO, PH_DATA, PH_DEVR: begin
                if (send_bit_tick(qtr, sda)) enter_phase(PH_STOP_ERR, 8'h00);
            end
            PH_RX: begin
                if (bc < BYTE_BITS && tc == 2 * qtr - 1)
                    sh = {sh[6:0], sda};
                tc++;
                if (tc >= 4 * qtr) begin
                    tc = '0;
                    bc++;
                    if (bc == BYTE_BITS) rd_byte = sh;
                    if (bc > BYTE_BITS) enter_phase(PH_STOP, 8'h00);
                end
            end
            PH_STOP, PH_STOP_ERR: begin
                tc++;
                if (tc >= 4 * qtr) begin
                    if (ph == PH_STOP_ERR) begin
                        r.ack_error = 1'b1;
                        r.done_res = 1'b1;
                        enter_phase(PH_IDLE, 8'h00);
                    end else if (h_wr && c_wait != '0) begin
                        enter_phase(PH_WAIT, 8'h00);
                    end else begin
                        r.done_res = 1'b1;
                        enter_phase(PH_IDLE, 8'h00);
                    end
                end
            end
            PH_WAIT: begin
                tc++;
                if (tc >= c_wait) begin
                    r.done_res = 1'b1;
                    enter_phase(PH_IDLE, 8'h00);
                end
            end
            default: enter_phase(PH_IDLE, 8'h00);
        endcase

        qi = tc / qtr;
        r.scl_level = 1'b1;
        r.sda_drive_low = 1'b0;
        case (ph)
            PH_START, PH_RSTART: begin
                r.scl_level = (qi == 1 || qi == 2);
                r.sda_drive_low = (qi >= 2);
            end
            PH_DEV, PH_AHI, PH_ALO, PH_DATA, PH_DEVR: begin
                if (bc < BIT_ACK_SETUP) begin
                    r.scl_level = (qi == 1 || qi == 2);
                    r.sda_drive_low = !sh[7];
                end else begin
                    r.scl_level = (bc == BIT_ACK_POLL);
                end
            end
            PH_RX: r.scl_level = (qi == 1 || qi == 2);
            PH_STOP, PH_STOP_ERR: begin
                r.scl_level = (qi != 0);
                r.sda_drive_low = (qi <= 1);
            end
            default: ;
        endcase
        r.busy_res = (ph != PH_IDLE);
        r.read_data = rd_byte;
        return r;
    endfunction

    task automatic send_tick(input logic [1:0] op, input logic [15:0] addr,
                             input logic [7:0] wdata, input logic sda);
        int gap;
        gap = tx_jitter ? $urandom_range(0, 11) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = {5'd0, sda, wdata, addr, op};
        do @(posedge aclk); while (!s_tready);
        expected_pins_q.push_back(step_bus_sequencer(op, addr, wdata, sda));
        ticks_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_pins_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_DEV_ADDR:   c_dev = val[6:0];
            CFG_WIDE_MODE:  c_wide = val[0];
            CFG_QUARTER:    c_quarter = val[15:0];
            CFG_ACK_TMO:    c_ack_tmo = val[7:0];
            CFG_WRITE_WAIT: c_wait = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [6:0] dev, input logic wide, input logic [15:0] qtr,
                             input logic [7:0] tmo, input logic [31:0] wait_ticks);
        wait_drained();
        write_reg(CFG_DEV_ADDR, {25'd0, dev});
        write_reg(CFG_WIDE_MODE, {31'd0, wide});
        write_reg(CFG_QUARTER, {16'd0, qtr});
        write_reg(CFG_ACK_TMO, {24'd0, tmo});
        write_reg(CFG_WRITE_WAIT, wait_ticks);
    endtask

    task automatic idle_ticks(input int count);
        repeat (count)
            send_tick(($urandom_range(0, 1) == 0) ? OP_NONE : OP_UNUSED,
                      16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // plays the eeprom side: acks each sent byte after a short random delay,
    // or holds sda high on the ack with ordinal fail_ack so that it times out
    task automatic run_transfer(input logic [1:0] op, input logic [15:0] addr,
                                input logic [7:0] wdata, input int fail_ack);
        int   ack_idx;
        int   hold;
        bit   polling;
        logic sda;
        logic [1:0] noise_op;
        ack_idx = 0;
        hold = 0;
        polling = 1'b0;
        send_tick(op, addr, wdata, 1'($urandom));
        while (ph != PH_IDLE) begin
            if (ph inside {PH_DEV, PH_AHI, PH_ALO, PH_DATA, PH_DEVR} && bc == BIT_ACK_POLL) begin
                if (!polling) begin
                    polling = 1'b1;
                    if (ack_idx == fail_ack)
                        hold = 300;
                    else if (c_ack_tmo <= 12 && $urandom_range(0, 3) == 0)
                        hold = c_ack_tmo;
                    else
                        hold = $urandom_range(0, (c_ack_tmo < 3) ? c_ack_tmo : 3);
                end
                sda = (hold > 0);
                if (hold > 0) hold--;
            end else begin
                if (polling) begin
                    polling = 1'b0;
                    ack_idx++;
                end
                sda = 1'($urandom);
            end
            // requests while busy must be ignored
            noise_op = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : OP_NONE;
            send_tick(noise_op, 16'($urandom), 8'($urandom), sda);
        end
    endtask

    task automatic flag_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            fault_count++;
            $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic check_pins(input logic [15:0] bus);
        res_t got;
        res_t want;
        got = res_t'(bus[12:0]);
        if (expected_pins_q.size() == 0) begin
            fault_count++;
            $display("%0t unexpected transaction expected none actual %0h", $time, bus);
            return;
        end
        want = expected_pins_q.pop_front();
        flag_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
        flag_field("sda_drive_low", 8'(want.sda_drive_low), 8'(got.sda_drive_low));
        flag_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        flag_field("done_res", 8'(want.done_res), 8'(got.done_res));
        flag_field("read_data", want.read_data, got.read_data);
        flag_field("ack_error", 8'(want.ack_error), 8'(got.ack_error));
        flag_field("pad bits", 8'd0, 8'(bus[15:13]));
    endtask

    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = rx_jitter ? $urandom_range(0, 11) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
            @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_pins(m_tdata);
        end
    end

    task automatic test_idle_after_reset();
        send_tick(OP_NONE, 16'h0000, 8'h00, 1'b0);
        send_tick(OP_UNUSED, 16'hFFFF, 8'hFF, 1'b1);
        send_tick(OP_UNUSED, 16'h0000, 8'h00, 1'b0);
        send_tick(OP_NONE, 16'hFFFF, 8'hFF, 1'b1);
    endtask

    task automatic test_narrow_write();
        // zero write wait: done right after stop
        configure(7'd80, 1'b0, 16'd1, 8'd4, 32'd0);
        run_transfer(OP_WRITE, 16'hFFFF, 8'hA5, -1);
    endtask

    task automatic test_narrow_read();
        tx_jitter = 1'b1;
        configure(7'd80, 1'b0, 16'd2, 8'd4, 32'd5);
        run_transfer(OP_READ, 16'h0700, 8'h00, -1);
    endtask

    task automatic test_wide_access();
        rx_jitter = 1'b1;
        configure(7'h55, 1'b1, 16'd1, 8'd3, 32'd7);
        run_transfer(OP_WRITE, 16'hFFFF, 8'h00, -1);
    endtask

    task automatic test_quarter_zero();
        configure(7'h2A, 1'b0, 16'd0, 8'd1, 32'd1);
        run_transfer(OP_WRITE, 16'hABCD, 8'h81, 0);
    endtask

    task automatic test_ack_timeout();
        tx_jitter = 1'b0;
        configure(7'd80, 1'b0, 16'd1, 8'd1, 32'd10);
        run_transfer(OP_READ, 16'h0300, 8'h00, 2);
    endtask

    task automatic test_extreme_settings();
        tx_jitter = 1'b1;
        // widest register values, idle ticks only at this bus period
        configure(7'd127, 1'b1, 16'hFFFF, 8'd255, 32'hFFFF_FFFF);
        idle_ticks(6);
    endtask

    task automatic test_random_traffic();
        int xfers;
        int fail_ack;
        xfers = 0;
        while (ticks_sent < 850) begin
            if (xfers % 3 == 0)
                configure(7'($urandom_range(0, 127)), 1'($urandom),
                          ($urandom_range(0, 9) == 0) ? 16'd0 :
                          ($urandom_range(0, 2) == 0) ? 16'($urandom_range(2, 3)) : 16'd1,
                          ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 20))
                                                      : 8'($urandom_range(1, 6)),
                          32'($urandom_range(0, 12)));
            tx_jitter = 1'($urandom);
            rx_jitter = 1'($urandom);
            idle_ticks($urandom_range(0, 3));
            fail_ack = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : -1;
            run_transfer(2'($urandom_range(1, 2)), 16'($urandom), 8'($urandom), fail_ack);
            xfers++;
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        reset_sequencer();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_idle_after_reset();
        test_narrow_write();
        test_narrow_read();
        test_wide_access();
        test_quarter_zero();
        test_ack_timeout();
        test_extreme_settings();
        test_random_traffic();

        wait_drained();
        repeat (4) @(posedge aclk);
        if (fault_count == 0) begin
            $display("i2c_eeprom_byte_master: match");
        end else begin
            $display("i2c_eeprom_byte_master: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/i2cee_pkg.sv
hw/rtl/i2cee_cfg.sv
hw/rtl/i2cee_step.sv
hw/rtl/i2c_eeprom_byte_master.sv
dv/tb_i2c_eeprom_byte_master.sv
